// ----- hw/rtl/sbl_pkg.sv -----
// ----------------------------------------------------------------------------
// sbl_pkg: shared types and constants of the stack blur line filter
// Field widths, scaling tables indexed by radius, and the structs passed
// between the sequencer, the running-sum stage and the output stage.
// ----------------------------------------------------------------------------
package sbl_pkg;

    localparam int ALPHA_W  = 8;
    localparam int RADIUS_W = 6;
    localparam int SIDE_W   = 14;   // incoming / outgoing sums
    localparam int TOTAL_W  = 20;   // weighted window total
    localparam int SEEN_W   = 7;
    localparam int STEP_W   = RADIUS_W + 1;
    localparam int SQ_W     = 13;   // (r+1)^2, at most 64*64
    localparam int MUL_W    = 10;
    localparam int SHR_W    = 5;
    localparam int TAB_N    = 64;
    localparam int PROD_W   = TOTAL_W + MUL_W;

    localparam logic [SEEN_W-1:0] SEEN_CAP = 7'd127;

    // Reciprocal multiplier for the triangular weight total (r+1)^2
    localparam logic [MUL_W-1:0] MUL_TAB [TAB_N] = '{
        10'd512, 10'd512, 10'd456, 10'd512, 10'd328, 10'd456, 10'd335, 10'd512,
        10'd405, 10'd328, 10'd271, 10'd456, 10'd388, 10'd335, 10'd292, 10'd512,
        10'd454, 10'd405, 10'd364, 10'd328, 10'd298, 10'd271, 10'd496, 10'd456,
        10'd420, 10'd388, 10'd360, 10'd335, 10'd312, 10'd292, 10'd273, 10'd512,
        10'd482, 10'd454, 10'd428, 10'd405, 10'd383, 10'd364, 10'd345, 10'd328,
        10'd312, 10'd298, 10'd284, 10'd271, 10'd259, 10'd496, 10'd475, 10'd456,
        10'd437, 10'd420, 10'd404, 10'd388, 10'd374, 10'd360, 10'd347, 10'd335,
        10'd323, 10'd312, 10'd302, 10'd292, 10'd282, 10'd273, 10'd265, 10'd512
    };

    // Matching right shift
    localparam logic [SHR_W-1:0] SHR_TAB [TAB_N] = '{
        5'd9,  5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
        5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17,
        5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18,
        5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21
    };

    typedef enum logic {
        ST_STREAM,
        ST_FLUSH
    } line_state_t;

    typedef enum logic {
        OP_FILL,
        OP_PUSH
    } sum_op_t;

    // Where a window value comes from
    typedef enum logic [1:0] {
        SRC_MEM,     // window memory read data
        SRC_FIRST,   // slot not yet written this line: first sample
        SRC_NEW      // slot written by this same push
    } win_src_t;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [STEP_W-1:0]   side;
        logic [SQ_W-1:0]     square;
        logic [MUL_W-1:0]    mul;
        logic [SHR_W-1:0]    shr;
    } blur_cfg_t;

    typedef struct packed {
        logic               valid;
        sum_op_t            op;
        logic               emit;
        logic               last;
        logic [ALPHA_W-1:0] sample;
        logic [ALPHA_W-1:0] first;
        win_src_t           old_src;
        win_src_t           cen_src;
    } sum_issue_t;

    typedef struct packed {
        logic valid;
        logic last;
    } emit_t;

endpackage

// ----- hw/rtl/sbl_window_ram.sv -----
// ----------------------------------------------------------------------------
// sbl_window_ram: sample window memory
// One write port and two registered read ports; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module sbl_window_ram
    import sbl_pkg::*;
#(
    parameter int DEPTH = 125,
    parameter int AW    = 7
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [ALPHA_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr_a,
    input  logic [AW-1:0]      raddr_b,
    output logic [ALPHA_W-1:0] rdata_a,
    output logic [ALPHA_W-1:0] rdata_b
);

    logic [ALPHA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hw/rtl/sbl_line_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbl_line_ctrl: line sequencer and window addressing
// Holds the radius register, accepts samples, runs the end-of-line flush,
// drives the window memory and issues one sum update per step.
// ----------------------------------------------------------------------------
module sbl_line_ctrl
    import sbl_pkg::*;
#(
    parameter int MAX_RADIUS = 62,
    parameter int AW         = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ALPHA_W-1:0]  in_alpha,
    input  logic                in_last,
    output logic                ram_we,
    output logic                ram_re,
    output logic [AW-1:0]       ram_waddr,
    output logic [ALPHA_W-1:0]  ram_wdata,
    output logic [AW-1:0]       ram_raddr_a,
    output logic [AW-1:0]       ram_raddr_b,
    output blur_cfg_t           cfg,
    output sum_issue_t          issue
);

    line_state_t         state_reg, state_next;
    blur_cfg_t           cfg_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   flush_seen_reg;
    logic [RADIUS_W-1:0] flush_step_reg;
    logic [AW-1:0]       ptr_reg;
    logic                wrap_reg;
    logic [ALPHA_W-1:0]  first_reg;
    logic [ALPHA_W-1:0]  edge_reg;
    sum_issue_t          issue_reg, issue_next;

    logic                in_fire;
    logic                fire;
    logic                flush_done;
    logic [RADIUS_W-1:0] new_radius;
    logic [STEP_W-1:0]   new_side;
    logic [AW:0]         r_w;
    logic [AW-1:0]       dlast;
    logic [AW:0]         dsize;
    logic [AW-1:0]       ptr_nx;
    logic [AW:0]         cidx_sum;
    logic [AW-1:0]       cidx;
    logic [SEEN_W:0]     flush_pos;

    // window geometry for the current radius
    assign r_w   = (AW+1)'(cfg_reg.radius);
    assign dlast = AW'({r_w, 1'b0});
    assign dsize = {1'b0, dlast} + (AW+1)'(1);

    assign ptr_nx   = (ptr_reg == dlast) ? '0 : ptr_reg + AW'(1);
    assign cidx_sum = {1'b0, ptr_nx} + r_w;
    assign cidx     = (cidx_sum > {1'b0, dlast}) ? AW'(cidx_sum - dsize) : AW'(cidx_sum);

    assign flush_pos  = {1'b0, flush_seen_reg} + (SEEN_W+1)'(flush_step_reg);
    assign flush_done = (flush_step_reg == cfg_reg.radius);

    assign in_fire = in_valid && in_ready;

    // radius clamp and derived scale values
    assign new_radius = (32'(cfg_wr_data) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS) : cfg_wr_data;
    assign new_side   = STEP_W'(new_radius) + STEP_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_STREAM:
            begin
                if (in_fire && in_last && (cfg_reg.radius != '0))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (en && flush_done)
                begin
                    state_next = ST_STREAM;
                end
            end
            default:
            begin
                state_next = ST_STREAM;
            end
        endcase
        if (cfg_wr_en)
        begin
            state_next = ST_STREAM;
        end
    end

    // outputs: handshake, memory access and sum issue
    always_comb
    begin
        in_ready           = 1'b0;
        fire               = 1'b0;
        issue_next         = '0;
        issue_next.op      = OP_PUSH;
        issue_next.first   = first_reg;
        issue_next.old_src = wrap_reg ? SRC_MEM : SRC_FIRST;
        if (cidx == ptr_reg)
        begin
            issue_next.cen_src = SRC_NEW;
        end
        else if (wrap_reg || (cidx < ptr_reg))
        begin
            issue_next.cen_src = SRC_MEM;
        end
        else
        begin
            issue_next.cen_src = SRC_FIRST;
        end
        unique case (state_reg)
            ST_STREAM:
            begin
                in_ready          = en;
                fire              = in_valid && en;
                issue_next.sample = in_alpha;
                issue_next.op     = (seen_reg == '0) ? OP_FILL : OP_PUSH;
                issue_next.emit   = (seen_reg >= SEEN_W'(cfg_reg.radius));
                issue_next.last   = in_last && (cfg_reg.radius == '0);
            end
            ST_FLUSH:
            begin
                fire              = en;
                issue_next.sample = edge_reg;
                issue_next.emit   = (flush_pos >= (SEEN_W+1)'(cfg_reg.radius));
                issue_next.last   = flush_done;
            end
            default:
            begin
                fire = 1'b0;
            end
        endcase
        issue_next.valid = fire;
        ram_we      = fire && (issue_next.op == OP_PUSH);
        ram_re      = ram_we;
        ram_waddr   = ptr_reg;
        ram_wdata   = issue_next.sample;
        ram_raddr_a = ptr_reg;
        ram_raddr_b = cidx;
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_STREAM;
            cfg_reg.radius <= '0;
            cfg_reg.side   <= STEP_W'(1);
            cfg_reg.square <= SQ_W'(1);
            cfg_reg.mul    <= MUL_TAB[0];
            cfg_reg.shr    <= SHR_TAB[0];
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cfg_reg.radius <= new_radius;
                cfg_reg.side   <= new_side;
                cfg_reg.square <= SQ_W'(new_side * new_side);
                cfg_reg.mul    <= MUL_TAB[new_radius];
                cfg_reg.shr    <= SHR_TAB[new_radius];
            end
        end
    end

    // line position, window pointer and fill tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= '0;
            flush_seen_reg <= '0;
            flush_step_reg <= '0;
            ptr_reg        <= '0;
            wrap_reg       <= 1'b0;
            issue_reg      <= '0;
        end
        else
        begin
            if (en)
            begin
                issue_reg <= issue_next;
            end
            if (cfg_wr_en)
            begin
                seen_reg <= '0;
            end
            else if (in_fire)
            begin
                if (in_last)
                begin
                    seen_reg       <= '0;
                    flush_seen_reg <= seen_reg;
                    flush_step_reg <= RADIUS_W'(1);
                end
                else if (seen_reg != SEEN_CAP)
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
            end
            else if (fire)
            begin
                flush_step_reg <= flush_step_reg + RADIUS_W'(1);
            end
            // pointer restarts on a fill, advances on each push
            if (fire)
            begin
                if (issue_next.op == OP_FILL)
                begin
                    ptr_reg  <= '0;
                    wrap_reg <= 1'b0;
                end
                else
                begin
                    ptr_reg  <= ptr_nx;
                    wrap_reg <= wrap_reg || (ptr_reg == dlast);
                end
            end
        end
    end

    // sample payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            edge_reg <= in_alpha;
            if (seen_reg == '0)
            begin
                first_reg <= in_alpha;
            end
        end
    end

    assign cfg   = cfg_reg;
    assign issue = issue_reg;

endmodule

// ----- hw/rtl/sbl_sum_unit.sv -----
// ----------------------------------------------------------------------------
// sbl_sum_unit: running sums of the stack window
// Loads the sums on a line fill and updates total, incoming and outgoing
// sums on each push from the window memory read data.
// ----------------------------------------------------------------------------
module sbl_sum_unit
    import sbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  blur_cfg_t          cfg,
    input  sum_issue_t         issue,
    input  logic [ALPHA_W-1:0] rd_old,
    input  logic [ALPHA_W-1:0] rd_cen,
    output logic [TOTAL_W-1:0] total,
    output emit_t              emit
);

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [SIDE_W-1:0]  in_sum_reg, in_sum_next;
    logic [SIDE_W-1:0]  out_sum_reg, out_sum_next;
    emit_t              emit_reg;
    logic [ALPHA_W-1:0] oldest;
    logic [ALPHA_W-1:0] centre;

    // pick window values
    always_comb
    begin
        case (issue.old_src)
            SRC_MEM:   oldest = rd_old;
            SRC_NEW:   oldest = issue.sample;
            default:   oldest = issue.first;
        endcase
        case (issue.cen_src)
            SRC_MEM:   centre = rd_cen;
            SRC_NEW:   centre = issue.sample;
            default:   centre = issue.first;
        endcase
    end

    // sum update
    always_comb
    begin
        if (issue.op == OP_FILL)
        begin
            total_next   = TOTAL_W'(issue.sample) * TOTAL_W'(cfg.square);
            out_sum_next = SIDE_W'(issue.sample) * SIDE_W'(cfg.side);
            in_sum_next  = SIDE_W'(issue.sample) * SIDE_W'(cfg.radius);
        end
        else
        begin
            total_next   = total_reg - TOTAL_W'(out_sum_reg) + TOTAL_W'(in_sum_reg)
                         + TOTAL_W'(issue.sample);
            out_sum_next = out_sum_reg - SIDE_W'(oldest) + SIDE_W'(centre);
            in_sum_next  = in_sum_reg + SIDE_W'(issue.sample) - SIDE_W'(centre);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            in_sum_reg  <= '0;
            out_sum_reg <= '0;
            emit_reg    <= '0;
        end
        else if (en)
        begin
            emit_reg.valid <= issue.valid && issue.emit;
            emit_reg.last  <= issue.last;
            if (issue.valid)
            begin
                total_reg   <= total_next;
                in_sum_reg  <= in_sum_next;
                out_sum_reg <= out_sum_next;
            end
        end
    end

    assign total = total_reg;
    assign emit  = emit_reg;

endmodule

// ----- hw/rtl/sbl_scale_out.sv -----
// ----------------------------------------------------------------------------
// sbl_scale_out: weight normalization and output register
// Multiplies the window total by the reciprocal for the radius, shifts,
// and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module sbl_scale_out
    import sbl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  blur_cfg_t          cfg,
    input  logic [TOTAL_W-1:0] total,
    input  emit_t              emit,
    output logic               en,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ALPHA_W-1:0] out_alpha,
    output logic               out_last
);

    logic               valid_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               last_reg;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  scaled;

    // pipeline advances whenever the output slot is free or being taken
    assign en = !valid_reg || out_ready;

    assign product = PROD_W'(total) * PROD_W'(cfg.mul);
    assign scaled  = product >> cfg.shr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && emit.valid)
        begin
            alpha_reg <= scaled[ALPHA_W-1:0];
            last_reg  <= emit.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_alpha = alpha_reg;
    assign out_last  = last_reg;

endmodule

// ----- hw/rtl/stack_blur_line_filter_unit.sv -----
// ----------------------------------------------------------------------------
// stack_blur_line_filter_unit: one-dimensional stack blur of alpha samples
// Samples of a line enter on the s_axis channel, tlast on the final sample.
// Each output is the triangular weighted mean of 2r+1 neighbors, the first
// and last samples replicated past the line edges.
//
// Usage:
//   - cfg_wr_en/cfg_wr_data set the blur radius (clamped to MAX_RADIUS) and
//     start a new line; write only while the block is idle.
//   - One sample is taken per cycle unless m_axis stalls. Result n reaches
//     m_axis through the issue, sum and output registers after sample n+r
//     is taken. At line end the sequencer runs r more window pushes, one
//     per cycle unless m_axis stalls, with s_axis_tready low; the last of them carries m_axis_tlast.
//   - Throughput is one window update per cycle, set by the single
//     read-modify-write pass through the window memory and the sum stage.
//   - A stall on m_axis holds the whole pipeline, and s_axis_tready drops.
//   - Reset clears the radius to zero and the line position; the window
//     memory needs no clearing, since slots not yet written on the current
//     line read as the line's first sample.
// ----------------------------------------------------------------------------
module stack_blur_line_filter_unit
    import sbl_pkg::*;
#(
    parameter int MAX_RADIUS = 62
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] alpha_in
    input  logic                s_axis_tlast,   // line_end_in
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] alpha_out
    output logic                m_axis_tlast    // line_end_out
);

    localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int AW        = $clog2(WIN_DEPTH);

    logic               en;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [ALPHA_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr_a;
    logic [AW-1:0]      ram_raddr_b;
    logic [ALPHA_W-1:0] rd_old;
    logic [ALPHA_W-1:0] rd_cen;
    blur_cfg_t          cfg;
    sum_issue_t         issue;
    logic [TOTAL_W-1:0] total;
    emit_t              emit;

    sbl_line_ctrl #(
        .MAX_RADIUS (MAX_RADIUS),
        .AW         (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_alpha    (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .ram_we      (ram_we),
        .ram_re      (ram_re),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .cfg         (cfg),
        .issue       (issue)
    );

    sbl_window_ram #(
        .DEPTH (WIN_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rd_old),
        .rdata_b (rd_cen)
    );

    sbl_sum_unit u_sum (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .cfg    (cfg),
        .issue  (issue),
        .rd_old (rd_old),
        .rd_cen (rd_cen),
        .total  (total),
        .emit   (emit)
    );

    sbl_scale_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .total     (total),
        .emit      (emit),
        .en        (en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_alpha (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
